FILE: src/device_sighting_probe_table_core_macros.svh
// Assertion macros shared by the sighting table modules.
`ifndef DEVICE_SIGHTING_PROBE_TABLE_CORE_MACROS_SVH
`define DEVICE_SIGHTING_PROBE_TABLE_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define DSPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dspt assertion failed");
// Next-cycle implication, checked while out of reset.
`define DSPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dspt assertion failed");
`else
`define DSPT_ASSERT_NOW(lbl, ante, cons)
`define DSPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/dspt_pkg.sv
// Shared constants, types and helpers of the device sighting table.
`timescale 1ns / 1ps
package dspt_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int START_W     = 6;
  localparam int ADDR_W      = 48;
  localparam int KIND_W      = 8;
  localparam int LEVEL_W     = 8;
  localparam int TICK_W      = 32;
  localparam int OUTCOME_W   = 2;
  localparam int COUNT_W     = 7;
  localparam int COUNT_MAX   = 127;
  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = -8'sd50;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_DROPPED  = 2'd0,
    OUT_UPDATED  = 2'd1,
    OUT_INSERTED = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_t;

  // One stored table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
    logic [TICK_W-1:0] seen_tick;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic probe_next;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic faint;
    logic hit;
    logic empty;
    logic last;
  } ctrl_status_t;

  // Reduce a home slot onto the table; a constant lookup over all codes.
  function automatic logic [SLOT_W-1:0] home_slot(input logic [START_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**START_W; i++) begin
      if (s == START_W'(i)) begin
        r = SLOT_W'(i % TABLE_SLOTS);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/device_sighting_probe_table_core.sv
// Top level of the device sighting table: a linear-probing hash table.
// Usage:
//   Input channel (in_valid/in_ready) carries one sighting request: address,
//   address type, signal level, home slot and current tick. Output channel
//   (out_valid/out_ready) returns one result per request: outcome, slot used
//   and the running count of inserted devices. cfg_we writes the signed
//   signal threshold; write it only while idle.
// Timing:
//   A weak sighting has its result registered at acceptance and skips the probe
//   walk. Otherwise the probe walk reads one table slot per cycle from the
//   single memory read port; a request resolves at its k-th probe (1 to 64),
//   and its result is then registered and loaded into the output register.
//   One request is in flight at a time; the next is accepted only after the
//   result has been loaded into the output register.
// Reset:
//   Synchronous rst_n clears all valid marks and the insert count, and sets
//   the threshold to -50. No clearing pass is needed.
// Stalls:
//   While out_ready is low the result holds in the output register; the next
//   request is still accepted and probed, then waits until the register frees.
`timescale 1ns / 1ps
module device_sighting_probe_table_core
  import dspt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [LEVEL_W-1:0] cfg_rssi_threshold,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADDR_W-1:0]         in_device_address,
  input  logic [KIND_W-1:0]         in_address_kind,
  input  logic signed [LEVEL_W-1:0] in_signal_level,
  input  logic [START_W-1:0]        in_start_slot,
  input  logic [TICK_W-1:0]         in_now_tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUTCOME_W-1:0]      out_outcome,
  output logic [5:0]                out_slot_used,
  output logic [COUNT_W-1:0]        out_devices_inserted
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  // Sequencer.
  dspt_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table storage and result path.
  dspt_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_rssi_threshold   (cfg_rssi_threshold),
    .in_device_address    (in_device_address),
    .in_address_kind      (in_address_kind),
    .in_signal_level      (in_signal_level),
    .in_start_slot        (in_start_slot),
    .in_now_tick          (in_now_tick),
    .out_outcome          (out_outcome),
    .out_slot_used        (out_slot_used),
    .out_devices_inserted (out_devices_inserted)
  );

endmodule

FILE: src/dspt_datapath.sv
// Datapath: request capture, entry memory, valid bits, count and result registers.
`timescale 1ns / 1ps
`include "device_sighting_probe_table_core_macros.svh"
module dspt_datapath
  import dspt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_cmd_t                 cmd,
  output ctrl_status_t              st,
  input  logic                      cfg_we,
  input  logic signed [LEVEL_W-1:0] cfg_rssi_threshold,
  input  logic [ADDR_W-1:0]         in_device_address,
  input  logic [KIND_W-1:0]         in_address_kind,
  input  logic signed [LEVEL_W-1:0] in_signal_level,
  input  logic [START_W-1:0]        in_start_slot,
  input  logic [TICK_W-1:0]         in_now_tick,
  output logic [OUTCOME_W-1:0]      out_outcome,
  output logic [5:0]                out_slot_used,
  output logic [COUNT_W-1:0]        out_devices_inserted
);

  logic signed [LEVEL_W-1:0] threshold_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [KIND_W-1:0]         kind_r;
  logic [TICK_W-1:0]         tick_r;
  logic [SLOT_W-1:0]         probe_slot_r;
  logic [SLOT_W-1:0]         probe_cnt_r;
  logic [SLOT_W-1:0]         next_slot;
  logic [SLOT_W-1:0]         rd_idx;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr_r;
  logic                      rd_valid_r;
  logic [TABLE_SLOTS-1:0]    valid_r;
  entry_t                    mem [TABLE_SLOTS];
  entry_t                    wr_entry;
  logic [COUNT_W-1:0]        count_r;
  logic                      count_bump;
  outcome_t                  res_outcome_r;
  logic [5:0]                res_slot_r;
  logic [OUTCOME_W-1:0]      out_outcome_r;
  logic [5:0]                out_slot_r;
  logic [COUNT_W-1:0]        out_count_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_rssi_threshold;
    end
  end

  // Status toward the controller.
  assign st.faint = in_signal_level < threshold_r;
  assign st.empty = !rd_valid_r;
  assign st.hit   = rd_valid_r && (rd_addr_r == addr_r);
  assign st.last  = probe_cnt_r == SLOT_W'(TABLE_SLOTS - 1);

  // Probe address: home slot on capture, then the next slot with wrap.
  assign next_slot = (probe_slot_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0
                                                                : probe_slot_r + SLOT_W'(1);
  assign rd_idx    = cmd.capture ? home_slot(in_start_slot) : next_slot;
  assign rd_en     = cmd.capture || cmd.probe_next;
  assign wr_entry  = '{addr: addr_r, kind: kind_r, seen_tick: tick_r};

  // Captured request fields and probe position.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r       <= in_device_address;
      kind_r       <= in_address_kind;
      tick_r       <= in_now_tick;
      probe_slot_r <= rd_idx;
      probe_cnt_r  <= '0;
    end else if (cmd.probe_next) begin
      probe_slot_r <= rd_idx;
      probe_cnt_r  <= probe_cnt_r + SLOT_W'(1);
    end
  end

  // Entry memory: registered read of the key, full-entry write on a commit that inserts or refreshes.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= mem[rd_idx].addr;
    end
    if (cmd.commit && (st.empty || st.hit)) begin
      mem[probe_slot_r] <= wr_entry;
    end
  end

  // Valid bits, read alongside the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
      if (cmd.commit && st.empty) begin
        valid_r[probe_slot_r] <= 1'b1;
      end
    end
  end

  // Saturating count of inserted devices.
  assign count_bump = cmd.commit && st.empty && (count_r != COUNT_W'(COUNT_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (count_bump) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  // Pending result, settled on a faint capture or on commit.
  always_ff @(posedge clk) begin
    if (cmd.capture && st.faint) begin
      res_outcome_r <= OUT_DROPPED;
      res_slot_r    <= '0;
    end else if (cmd.commit) begin
      priority if (st.empty) begin
        res_outcome_r <= OUT_INSERTED;
        res_slot_r    <= 6'(probe_slot_r);
      end else if (st.hit) begin
        res_outcome_r <= OUT_UPDATED;
        res_slot_r    <= 6'(probe_slot_r);
      end else begin
        res_outcome_r <= OUT_FULL;
        res_slot_r    <= '0;
      end
    end
  end

  // Output register, loaded when the result is handed out.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_outcome_r <= res_outcome_r;
      out_slot_r    <= res_slot_r;
      out_count_r   <= count_r;
    end
  end

  assign out_outcome          = out_outcome_r;
  assign out_slot_used        = out_slot_r;
  assign out_devices_inserted = out_count_r;

  // An insert below the limit bumps the count by one.
  `DSPT_ASSERT_NEXT(a_count_bump, count_bump, count_r == $past(count_r) + COUNT_W'(1))
  // The probe walk never steps past a full lap of the table.
  `DSPT_ASSERT_NOW(a_probe_bound, cmd.probe_next, !st.last)
  // An insert marks its slot as occupied.
  `DSPT_ASSERT_NEXT(a_insert_marks, cmd.commit && st.empty, valid_r[$past(probe_slot_r)])

endmodule

FILE: src/dspt_controller.sv
// Controller: sequences accept, probe walk, commit and result hand-off.
`timescale 1ns / 1ps
`include "device_sighting_probe_table_core_macros.svh"
module dspt_controller
  import dspt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ctrl_status_t st,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;
  logic   resolved;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign resolved  = st.empty || st.hit || st.last;

  // Commands for the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.capture = in_valid;
      S_PROBE: begin
        cmd.commit     = resolved;
        cmd.probe_next = !resolved;
      end
      S_DONE:  cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= st.faint ? S_DONE : S_PROBE;
          end
        end
        S_PROBE: begin
          if (resolved) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // A new result takes the output register as the old one leaves.
      priority if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A commit always leads to the hand-off state.
  `DSPT_ASSERT_NEXT(a_commit_done, cmd.commit, state_r == S_DONE)
  // A result is only loaded when the output register can take it.
  `DSPT_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_r || out_ready)
  // After an accepted request no second one is taken in the next cycle.
  `DSPT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

FILE: tb/tb_device_sighting_probe_table_core.sv
// Self-checking testbench for the device sighting probe table core.
`timescale 1ns / 1ps
module tb_device_sighting_probe_table_core
  import dspt_pkg::*;
();

  localparam int CLK_HALF     = 6;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  // Expected result of one sighting request.
  typedef struct {
    outcome_t               outcome;
    logic [5:0]             slot;
    logic [COUNT_W-1:0]     count;
  } sighting_result_t;

  // A device address together with the home slot it was first sent with.
  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [START_W-1:0] home;
  } known_device_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic signed [LEVEL_W-1:0] cfg_rssi_threshold;
  logic                      in_valid;
  logic                      in_ready;
  logic [ADDR_W-1:0]         in_device_address;
  logic [KIND_W-1:0]         in_address_kind;
  logic signed [LEVEL_W-1:0] in_signal_level;
  logic [START_W-1:0]        in_start_slot;
  logic [TICK_W-1:0]         in_now_tick;
  logic                      out_valid;
  logic                      out_ready;
  logic [OUTCOME_W-1:0]      out_outcome;
  logic [5:0]                out_slot_used;
  logic [COUNT_W-1:0]        out_devices_inserted;

  // Shadow copy of the sighting table used for prediction.
  logic                      tbl_valid [TABLE_SLOTS];
  logic [ADDR_W-1:0]         tbl_addr  [TABLE_SLOTS];
  logic [KIND_W-1:0]         tbl_kind  [TABLE_SLOTS];
  logic [TICK_W-1:0]         tbl_tick  [TABLE_SLOTS];
  logic [COUNT_W-1:0]        tbl_count;
  logic signed [LEVEL_W-1:0] tbl_threshold;

  sighting_result_t expected_results[$];
  known_device_t    known_devices[$];

  int  cur_threshold;
  bit  idling;
  int  error_count;
  int  cycle_count;
  int  requests_sent;
  int  results_seen;
  int  outcome_seen [4];

  device_sighting_probe_table_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_rssi_threshold   (cfg_rssi_threshold),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_device_address    (in_device_address),
    .in_address_kind      (in_address_kind),
    .in_signal_level      (in_signal_level),
    .in_start_slot        (in_start_slot),
    .in_now_tick          (in_now_tick),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_outcome          (out_outcome),
    .out_slot_used        (out_slot_used),
    .out_devices_inserted (out_devices_inserted)
  );

  // Clock.
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Run-time guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Walk the shadow table for one sighting and update it the way the block should.
  function automatic sighting_result_t predict_sighting(
    input logic [ADDR_W-1:0]         addr,
    input logic [KIND_W-1:0]         kind,
    input logic signed [LEVEL_W-1:0] level,
    input logic [START_W-1:0]        start,
    input logic [TICK_W-1:0]         tick
  );
    sighting_result_t res;
    int home;
    int s;
    bit done;
    res.outcome = OUT_FULL;
    res.slot    = '0;
    done        = 1'b0;
    if (level < tbl_threshold) begin
      res.outcome = OUT_DROPPED;
      res.count   = tbl_count;
      return res;
    end
    home = int'(start) % TABLE_SLOTS;
    for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
      s = (home + i) % TABLE_SLOTS;
      if (!tbl_valid[s]) begin
        tbl_valid[s] = 1'b1;
        tbl_addr[s]  = addr;
        tbl_kind[s]  = kind;
        tbl_tick[s]  = tick;
        if (tbl_count < COUNT_MAX) begin
          tbl_count = tbl_count + COUNT_W'(1);
        end
        res.outcome = OUT_INSERTED;
        res.slot    = s[5:0];
        done        = 1'b1;
      end else if (tbl_addr[s] == addr) begin
        tbl_kind[s] = kind;
        tbl_tick[s] = tick;
        res.outcome = OUT_UPDATED;
        res.slot    = s[5:0];
        done        = 1'b1;
      end
    end
    res.count = tbl_count;
    return res;
  endfunction

  // Check each returned result, then record each accepted request and threshold write.
  always @(posedge clk) begin
    sighting_result_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual outcome=%0d slot=%0d count=%0d",
                   $time, out_outcome, out_slot_used, out_devices_inserted);
        end else begin
          exp_res = expected_results.pop_front();
          outcome_seen[exp_res.outcome]++;
          if (out_outcome !== exp_res.outcome) begin
            error_count++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d", $time,
                     exp_res.outcome, out_outcome);
          end
          if (out_slot_used !== exp_res.slot) begin
            error_count++;
            $display("%0t: slot_used mismatch, expected %0d, actual %0d", $time,
                     exp_res.slot, out_slot_used);
          end
          if (out_devices_inserted !== exp_res.count) begin
            error_count++;
            $display("%0t: devices_inserted mismatch, expected %0d, actual %0d", $time,
                     exp_res.count, out_devices_inserted);
          end
        end
      end
      if (cfg_we) begin
        tbl_threshold = cfg_rssi_threshold;
      end
      if (in_valid && in_ready) begin
        requests_sent++;
        expected_results.push_back(predict_sighting(in_device_address, in_address_kind,
                                                     in_signal_level, in_start_slot,
                                                     in_now_tick));
      end
    end
  end

  // Result-side backpressure: random stalls while idling is on.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Send one sighting request; returns right after the accepting edge.
  task automatic send_sighting(
    input logic [ADDR_W-1:0]  addr,
    input logic [KIND_W-1:0]  kind,
    input int                 level,
    input logic [START_W-1:0] start,
    input logic [TICK_W-1:0]  tick
  );
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_device_address <= addr;
    in_address_kind   <= kind;
    in_signal_level   <= level[LEVEL_W-1:0];
    in_start_slot     <= start;
    in_now_tick       <= tick;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every outstanding result come back, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the signal threshold while the block is idle.
  task automatic set_threshold(input int value);
    wait_idle();
    cfg_rssi_threshold <= value[LEVEL_W-1:0];
    cfg_we             <= 1'b1;
    @(negedge clk);
    cfg_we             <= 1'b0;
    cur_threshold = value;
  endtask

  // Levels right at and around the reset threshold, and the extremes of the level field.
  task automatic test_reset_threshold();
    send_sighting(48'h0, 8'h00, -51, 6'd0, 32'h0);
    send_sighting(48'h0, 8'h00, -50, 6'd0, 32'h0);
    send_sighting(48'hFFFF_FFFF_FFFF, 8'hFF, 127, 6'd63, 32'hFFFF_FFFF);
    send_sighting(48'hFFFF_FFFF_FFFF, 8'hFF, -128, 6'd63, 32'h1);
  endtask

  // Refresh of existing entries, collisions, wrap-around and near-miss addresses.
  task automatic test_refresh_and_probe();
    send_sighting(48'h0, 8'hFF, 0, 6'd0, 32'h1234_5678);
    send_sighting(48'hA5A5_A5A5_A5A5, 8'h5A, -10, 6'd63, 32'h0000_0100);
    send_sighting(48'hA5A5_A5A5_A5A5, 8'hA5, -20, 6'd63, 32'h0000_0200);
    send_sighting(48'h0000_0000_0001, 8'h01, 30, 6'd0, 32'h8000_0000);
    send_sighting(48'h8000_0000_0000, 8'h80, 40, 6'd0, 32'h7FFF_FFFF);
    send_sighting(48'h0, 8'h11, 50, 6'd62, 32'h0000_0300);
    send_sighting(48'hFFFF_FFFF_FFFF, 8'h22, 60, 6'd0, 32'h0000_0400);
    send_sighting(48'h5A5A_5A5A_5A5A, 8'h33, -50, 6'd31, 32'h5555_AAAA);
    send_sighting(48'h5A5A_5A5A_5A5A, 8'hCC, 1, 6'd31, 32'hAAAA_5555);
  endtask

  // Both ends of the threshold range.
  task automatic test_threshold_extremes();
    set_threshold(-128);
    send_sighting(48'h1234_5678_9ABC, 8'h42, -128, 6'd10, 32'h0000_0500);
    send_sighting(48'h1234_5678_9ABC, 8'h43, 127, 6'd10, 32'h0000_0600);
    set_threshold(127);
    send_sighting(48'h0F0F_0F0F_0F0F, 8'h44, 126, 6'd20, 32'h0000_0700);
    send_sighting(48'h0F0F_0F0F_0F0F, 8'h45, 127, 6'd20, 32'h0000_0800);
    send_sighting(48'hF0F0_F0F0_F0F0, 8'h46, -128, 6'd21, 32'h0000_0900);
  endtask

  // One random sighting: weak, new device, revisit, near miss or noise.
  task automatic random_sighting(input int new_pct);
    int                 r;
    int                 level;
    int                 idx;
    logic [ADDR_W-1:0]  addr;
    logic [START_W-1:0] start;
    known_device_t      dev;
    r     = $urandom_range(0, 99);
    level = cur_threshold + int'($urandom_range(0, 127 - cur_threshold));
    addr  = ADDR_W'({$urandom, $urandom});
    start = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(60, 67));
    if (r < 12 && cur_threshold > -128) begin
      level = -128 + int'($urandom_range(0, cur_threshold + 127));
    end else if (r < 12 + new_pct || known_devices.size() == 0) begin
      dev.addr = addr;
      dev.home = start;
      if (known_devices.size() < 200) begin
        known_devices.push_back(dev);
      end
    end else if (r < 88) begin
      idx   = $urandom_range(0, known_devices.size() - 1);
      addr  = known_devices[idx].addr;
      start = ($urandom_range(0, 4) != 0) ? known_devices[idx].home : start;
    end else if (r < 94) begin
      idx  = $urandom_range(0, known_devices.size() - 1);
      addr = known_devices[idx].addr ^ (48'h1 << $urandom_range(0, ADDR_W - 1));
    end
    send_sighting(addr, KIND_W'($urandom), level, start, $urandom);
  endtask

  // Random traffic over several thresholds; the table fills and then runs full.
  task automatic test_random_traffic();
    int thresholds [5];
    int lengths [5];
    thresholds = '{-128, 127, 0, -128, -90};
    lengths    = '{260, 40, 200, 150, 150};
    thresholds[4] = int'($urandom_range(0, 255)) - 128;
    for (int p = 0; p < 5; p++) begin
      set_threshold(thresholds[p]);
      for (int n = 0; n < lengths[p]; n++) begin
        if (n % 50 == 0) begin
          idling = ($urandom_range(0, 3) != 0);
        end
        random_sighting(25);
      end
    end
  endtask

  // Closing stretch at the reset threshold with both sides always ready.
  task automatic test_back_to_back();
    set_threshold(-50);
    idling = 1'b0;
    for (int n = 0; n < 150; n++) begin
      random_sighting(10);
    end
  endtask

  // Test sequence.
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_rssi_threshold = '0;
    in_valid           = 1'b0;
    in_device_address  = '0;
    in_address_kind    = '0;
    in_signal_level    = '0;
    in_start_slot      = '0;
    in_now_tick        = '0;
    idling             = 1'b1;
    error_count        = 0;
    cycle_count        = 0;
    requests_sent      = 0;
    results_seen       = 0;
    outcome_seen       = '{0, 0, 0, 0};
    cur_threshold      = -50;
    tbl_threshold      = THRESHOLD_RESET;
    tbl_count          = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_threshold();
    test_refresh_and_probe();
    test_threshold_extremes();
    test_random_traffic();
    test_back_to_back();
    wait_idle();

    $display("Sent %0d sighting requests and checked %0d results", requests_sent,
             results_seen);
    $display("Outcomes: %0d dropped, %0d refreshed, %0d inserted, %0d table full",
             outcome_seen[OUT_DROPPED], outcome_seen[OUT_UPDATED],
             outcome_seen[OUT_INSERTED], outcome_seen[OUT_FULL]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
